// ----- rtl/mczt_pkg.sv -----
// Shared types, constants and helpers for the mouse cursor / zoom tracker.
// No dependencies; used by every module under rtl/.
package mczt_pkg;

  // Default geometry and zoom depth
  localparam int unsigned ZOOM_LEVELS_DEF = 16;
  localparam int unsigned SCREEN_W_DEF    = 640;
  localparam int unsigned SCREEN_H_DEF    = 480;

  // Screen span of the view in Q4.28: 3.0 wide and 2.0 high
  localparam int unsigned SPAN_X = 805306368;
  localparam int unsigned SPAN_Y = 536870912;

  // Hold-off counter saturation point and cursor start position
  localparam int unsigned HOLD_CAP  = 1000;
  localparam int unsigned POS_RESET = 200;

  // Configuration port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [2:0] {
    REG_HOLDOFF  = 3'd0,
    REG_PERIOD   = 3'd1,
    REG_MAX_STEP = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4
  } reg_idx_e;

  localparam logic [9:0]  HOLDOFF_RST  = 10'd200;
  localparam logic [9:0]  PERIOD_RST   = 10'd20;
  localparam logic [6:0]  MAX_STEP_RST = 7'd20;
  localparam logic [31:0] ORIGIN_X_RST = 32'hE000_0000;
  localparam logic [31:0] ORIGIN_Y_RST = 32'hF000_0000;

  // Load strobes of the arithmetic pipeline stages
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ld_t;

  // Cursor register width: enough for the screen and for the start position
  function automatic int unsigned pos_w(input int unsigned screen);
    int unsigned w;
    w = $clog2(screen);
    return (w > 8) ? w : 8;
  endfunction

endpackage

// ----- rtl/mczt_ctrl.sv -----
// Per-tick control state of the tracker: hold-off, cursor motion, zoom and
// publish decision. Depends on mczt_pkg.
module mczt_ctrl #(
  parameter int unsigned ZOOM_LEVELS = mczt_pkg::ZOOM_LEVELS_DEF,
  parameter int unsigned SCREEN_W    = mczt_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = mczt_pkg::SCREEN_H_DEF,
  localparam int unsigned ZoomW = $clog2(ZOOM_LEVELS),
  localparam int unsigned PosXW = mczt_pkg::pos_w(SCREEN_W),
  localparam int unsigned PosYW = mczt_pkg::pos_w(SCREEN_H)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             req_type_i,
  input  logic [7:0]       header_byte_i,
  input  logic [7:0]       x_byte_i,
  input  logic [7:0]       y_byte_i,
  input  logic             link_error_i,
  input  logic [9:0]       holdoff_ticks_i,
  input  logic [9:0]       publish_period_i,
  input  logic [6:0]       max_step_i,
  output logic             pub_o,
  output logic [PosXW-1:0] pos_x_o,
  output logic [PosYW-1:0] pos_y_o,
  output logic [ZoomW-1:0] org_lvl_o,
  output logic [ZoomW-1:0] zoom_o
);

  logic [PosXW-1:0]        pos_x_q, pos_x_d, mov_x;
  logic [PosYW-1:0]        pos_y_q, pos_y_d, mov_y;
  logic [ZoomW-1:0]        zoom_q, zoom_mid, zoom_fin;
  logic [ZoomW-1:0]        pub_lvl_q, pub_lvl_d;
  logic [10:0]             hold_q, hold_inc, hold_mid, hold_fin;
  logic [9:0]              tick_q, tick_d;
  logic                    left_q, left_d, right_q, right_d;
  logic signed [8:0]       raw_x, raw_y;
  logic signed [9:0]       adj_x, adj_y;
  logic signed [6:0]       dx, qy, dy;
  logic [6:0]              mag_x, mag_y;
  logic signed [PosXW+1:0] nx;
  logic signed [PosYW+1:0] ny;
  logic                    ok_x, ok_y, packet, still, zoom_in, zoom_out, pub, recentre;

  // Deltas: 9-bit two's complement, divided by 8 rounding toward zero, Y negated
  assign raw_x = $signed({header_byte_i[4], x_byte_i});
  assign raw_y = $signed({header_byte_i[5], y_byte_i});
  assign adj_x = 10'(raw_x) + (raw_x[8] ? 10'sd7 : 10'sd0);
  assign adj_y = 10'(raw_y) + (raw_y[8] ? 10'sd7 : 10'sd0);
  assign dx    = adj_x[9:3];
  assign qy    = adj_y[9:3];
  assign dy    = 7'sd0 - qy;
  assign mag_x = dx[6] ? 7'(7'sd0 - dx) : 7'(dx);
  assign mag_y = dy[6] ? 7'(7'sd0 - dy) : 7'(dy);

  // Candidate positions and on-screen checks
  assign nx   = (PosXW+2)'($signed({1'b0, pos_x_q})) + (PosXW+2)'(dx);
  assign ny   = (PosYW+2)'($signed({1'b0, pos_y_q})) + (PosYW+2)'(dy);
  assign ok_x = (mag_x < max_step_i) && !nx[PosXW+1] &&
                (nx[PosXW:0] < (PosXW+1)'(SCREEN_W));
  assign ok_y = (mag_y < max_step_i) && !ny[PosYW+1] &&
                (ny[PosYW:0] < (PosYW+1)'(SCREEN_H));

  assign packet = req_type_i && !link_error_i;
  assign still  = (dx == 7'sd0) && (dy == 7'sd0);
  assign mov_x  = (packet && ok_x) ? nx[PosXW-1:0] : pos_x_q;
  assign mov_y  = (packet && ok_y) ? ny[PosYW-1:0] : pos_y_q;

  // Hold-off saturates, then zoom in is tested before zoom out
  assign hold_inc = (hold_q > 11'(mczt_pkg::HOLD_CAP)) ? 11'(mczt_pkg::HOLD_CAP)
                                                       : hold_q + 11'd1;
  assign zoom_in  = packet && still && (zoom_q < ZoomW'(ZOOM_LEVELS - 1)) &&
                    (left_q != header_byte_i[0]) && (hold_inc >= {1'b0, holdoff_ticks_i});
  assign zoom_mid = zoom_in ? zoom_q + ZoomW'(1) : zoom_q;
  assign hold_mid = zoom_in ? 11'd0 : hold_inc;
  assign zoom_out = packet && still && (zoom_mid != '0) &&
                    (right_q != header_byte_i[1]) && (hold_mid >= {1'b0, holdoff_ticks_i});
  assign zoom_fin = zoom_out ? zoom_mid - ZoomW'(1) : zoom_mid;
  assign hold_fin = zoom_out ? 11'd0 : hold_mid;
  assign left_d   = packet ? header_byte_i[0] : left_q;
  assign right_d  = packet ? header_byte_i[1] : right_q;

  // Publish: level change sends the cursor to the corner
  assign pub       = (tick_q >= publish_period_i);
  assign recentre  = pub && (zoom_fin != pub_lvl_q);
  assign pos_x_d   = recentre ? '0 : mov_x;
  assign pos_y_d   = recentre ? '0 : mov_y;
  assign pub_lvl_d = pub ? zoom_fin : pub_lvl_q;
  assign tick_d    = pub ? 10'd1 : tick_q + 10'd1;

  // Advance the state by one tick per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= PosXW'(mczt_pkg::POS_RESET);
      pos_y_q   <= PosYW'(mczt_pkg::POS_RESET);
      zoom_q    <= '0;
      pub_lvl_q <= '0;
      hold_q    <= '0;
      tick_q    <= '0;
      left_q    <= 1'b0;
      right_q   <= 1'b0;
    end else if (step_i) begin
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      zoom_q    <= zoom_fin;
      pub_lvl_q <= pub_lvl_d;
      hold_q    <= hold_fin;
      tick_q    <= tick_d;
      left_q    <= left_d;
      right_q   <= right_d;
    end
  end

  assign pub_o     = pub;
  assign pos_x_o   = mov_x;
  assign pos_y_o   = mov_y;
  assign org_lvl_o = pub_lvl_q;
  assign zoom_o    = zoom_fin;

endmodule

// ----- rtl/mczt_point.sv -----
// One axis of the view origin: cursor-to-view scaling, origin stack memory
// and saturation. Depends on mczt_pkg.
module mczt_point #(
  parameter int unsigned ZOOM_LEVELS = mczt_pkg::ZOOM_LEVELS_DEF,
  parameter int unsigned SCREEN      = mczt_pkg::SCREEN_W_DEF,
  parameter int unsigned SPAN        = mczt_pkg::SPAN_X,
  localparam int unsigned ZoomW = $clog2(ZOOM_LEVELS),
  localparam int unsigned PosW  = mczt_pkg::pos_w(SCREEN)
) (
  input  logic               clk_i,
  input  mczt_pkg::pipe_ld_t ld_i,
  input  logic [PosW-1:0]    pos_i,
  input  logic [ZoomW-1:0]   s2_org_i,
  input  logic [ZoomW-1:0]   s2_zoom_i,
  input  logic               s3_pub_i,
  input  logic [ZoomW-1:0]   s3_org_i,
  input  logic [ZoomW-1:0]   s3_zoom_i,
  input  logic [31:0]        base_i,
  output logic [31:0]        view_o
);

  // span/screen split into quotient and remainder; remainder part divided
  // by the screen size through an exact reciprocal multiply
  localparam int unsigned Quo        = SPAN / SCREEN;
  localparam int unsigned Rem        = SPAN % SCREEN;
  localparam int unsigned QW         = $clog2(Quo + 1);
  localparam int unsigned RW         = $clog2(SCREEN);
  localparam int unsigned ProdQW     = PosW + QW;
  localparam int unsigned ProdRW     = PosW + RW;
  localparam int unsigned RecipK     = ProdRW + RW + 1;
  localparam int unsigned RecipW     = RecipK - $clog2(SCREEN) + 1;
  localparam logic [63:0] RecipM     = ((64'd1 << RecipK) + 64'(SCREEN) - 64'd1) /
                                       64'(SCREEN);
  localparam int unsigned RecipProdW = ProdRW + RecipW;
  localparam int unsigned QuotW      = ProdQW + 1;
  localparam int unsigned SumW       = ((QuotW > 32) ? QuotW : 32) + 2;

  logic [ProdQW-1:0]     prodq_d, prodq_q;
  logic [ProdRW-1:0]     prodr_d, prodr_q;
  logic [RecipProdW-1:0] recip;
  logic [QuotW-1:0]      quot_d, quot_q, offset;
  logic [31:0]           rd_org_q, rd_zoom_q, org_val, pnt;
  logic [31:0]           mem_q [ZOOM_LEVELS];
  logic signed [SumW-1:0] sum;
  logic                  over, deeper, wr_en;

  // Stage 2: products of the cursor with quotient and remainder
  assign prodq_d = ProdQW'(pos_i) * ProdQW'(Quo);
  assign prodr_d = ProdRW'(pos_i) * ProdRW'(Rem);

  always_ff @(posedge clk_i) begin
    if (ld_i.ld2) begin
      prodq_q <= prodq_d;
      prodr_q <= prodr_d;
    end
  end

  // Stage 3: floor(pos*span/screen) at full resolution
  assign recip  = RecipProdW'(prodr_q) * RecipProdW'(RecipM);
  assign quot_d = QuotW'(prodq_q) + QuotW'(recip[RecipProdW-1:RecipK]);

  // Scale by the published level and add the origin, saturating high
  assign org_val = (s3_org_i == '0) ? base_i : rd_org_q;
  assign offset  = quot_q >> s3_org_i;
  assign sum     = SumW'($signed(org_val)) + $signed(SumW'(offset));
  assign over    = !sum[SumW-1] && (sum[SumW-2:31] != '0);
  assign pnt     = over ? 32'h7FFF_FFFF : sum[31:0];

  assign deeper = (s3_zoom_i > s3_org_i);
  assign wr_en  = ld_i.ld4 && s3_pub_i && deeper;

  // Register quotient and stack reads; bypass a write landing on the same edge
  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      quot_q <= quot_d;
      if (wr_en && (s3_zoom_i == s2_org_i)) begin
        rd_org_q <= pnt;
      end else begin
        rd_org_q <= mem_q[s2_org_i];
      end
      if (wr_en && (s3_zoom_i == s2_zoom_i)) begin
        rd_zoom_q <= pnt;
      end else begin
        rd_zoom_q <= mem_q[s2_zoom_i];
      end
    end
  end

  // Store the new origin for a deeper level
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[s3_zoom_i] <= pnt;
    end
  end

  assign view_o = deeper ? pnt : ((s3_zoom_i == '0) ? base_i : rd_zoom_q);

endmodule

// ----- rtl/mouse_cursor_zoom_tracker_core.sv -----
// Top level of the mouse cursor / zoom tracker: APB registers, beat pipeline
// and result register. Depends on mczt_pkg, mczt_ctrl and mczt_point.
// Path: a beat passes the input register, the tick stage, stages 2 and 3 and the result register.
// Throughput: one beat per cycle while out_ready_i does not stall the output; the tick
// state is updated at the tick stage and the view arithmetic runs in three pipelined stages behind it.
// Reset: asynchronous, active low; registers take their defaults, cursor 200,200.
module mouse_cursor_zoom_tracker_core #(
  parameter int unsigned ZOOM_LEVELS = mczt_pkg::ZOOM_LEVELS_DEF,
  parameter int unsigned SCREEN_W    = mczt_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H    = mczt_pkg::SCREEN_H_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mczt_pkg::APB_AW-1:0] paddr,
  input  logic [mczt_pkg::APB_DW-1:0] pwdata,
  output logic [mczt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [7:0]                  header_byte_i,
  input  logic [7:0]                  x_byte_i,
  input  logic [7:0]                  y_byte_i,
  input  logic                        link_error_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        publish_o,
  output logic [9:0]                  cursor_x_o,
  output logic [8:0]                  cursor_y_o,
  output logic [3:0]                  zoom_level_o,
  output logic signed [31:0]          view_x_o,
  output logic signed [31:0]          view_y_o
);

  localparam int unsigned ZoomW = $clog2(ZOOM_LEVELS);
  localparam int unsigned PosXW = mczt_pkg::pos_w(SCREEN_W);
  localparam int unsigned PosYW = mczt_pkg::pos_w(SCREEN_H);

  // Configuration registers
  logic [9:0]  holdoff_q, period_q;
  logic [6:0]  max_step_q;
  logic [31:0] org_x_q, org_y_q;
  logic        cfg_wr;
  mczt_pkg::reg_idx_e cfg_idx;

  // Pipeline valids and stage payloads
  logic             v0_q, v1_q, v2_q, v3_q, out_v_q;
  logic             rdy0, rdy1, rdy2, rdy3, rdy4, step;
  mczt_pkg::pipe_ld_t ld;
  logic             req0_q, err0_q;
  logic [7:0]       hdr0_q, xb0_q, yb0_q;
  logic             pub_c, pub1_q, pub2_q, pub3_q;
  logic [PosXW-1:0] px_c, px1_q, px2_q, px3_q;
  logic [PosYW-1:0] py_c, py1_q, py2_q, py3_q;
  logic [ZoomW-1:0] org_c, org1_q, org2_q, org3_q;
  logic [ZoomW-1:0] zn_c, zn1_q, zn2_q, zn3_q;
  logic [31:0]      view_x, view_y;
  logic             recentre3;

  // Result register
  logic        pub_out_q;
  logic [9:0]  cx_out_q;
  logic [8:0]  cy_out_q;
  logic [3:0]  zoom_out_q;
  logic [31:0] vx_out_q, vy_out_q;

  // APB: zero wait state, write on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = mczt_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q  <= mczt_pkg::HOLDOFF_RST;
      period_q   <= mczt_pkg::PERIOD_RST;
      max_step_q <= mczt_pkg::MAX_STEP_RST;
      org_x_q    <= mczt_pkg::ORIGIN_X_RST;
      org_y_q    <= mczt_pkg::ORIGIN_Y_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mczt_pkg::REG_HOLDOFF:  holdoff_q  <= pwdata[9:0];
        mczt_pkg::REG_PERIOD:   period_q   <= pwdata[9:0];
        mczt_pkg::REG_MAX_STEP: max_step_q <= pwdata[6:0];
        mczt_pkg::REG_ORIGIN_X: org_x_q    <= pwdata;
        mczt_pkg::REG_ORIGIN_Y: org_y_q    <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      mczt_pkg::REG_HOLDOFF:  prdata = 32'(holdoff_q);
      mczt_pkg::REG_PERIOD:   prdata = 32'(period_q);
      mczt_pkg::REG_MAX_STEP: prdata = 32'(max_step_q);
      mczt_pkg::REG_ORIGIN_X: prdata = org_x_q;
      mczt_pkg::REG_ORIGIN_Y: prdata = org_y_q;
      default:                prdata = '0;
    endcase
  end

  // Ready chain: a stage takes a beat when empty or draining
  assign rdy4       = !out_v_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;
  assign step       = v0_q && rdy1;
  assign ld.ld2     = v1_q && rdy2;
  assign ld.ld3     = v2_q && rdy3;
  assign ld.ld4     = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy0) v0_q    <= in_valid_i;
      if (rdy1) v1_q    <= v0_q;
      if (rdy2) v2_q    <= v1_q;
      if (rdy3) v3_q    <= v2_q;
      if (rdy4) out_v_q <= v3_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      req0_q <= req_type_i;
      hdr0_q <= header_byte_i;
      xb0_q  <= x_byte_i;
      yb0_q  <= y_byte_i;
      err0_q <= link_error_i;
    end
  end

  mczt_ctrl #(
    .ZOOM_LEVELS(ZOOM_LEVELS),
    .SCREEN_W   (SCREEN_W),
    .SCREEN_H   (SCREEN_H)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .req_type_i      (req0_q),
    .header_byte_i   (hdr0_q),
    .x_byte_i        (xb0_q),
    .y_byte_i        (yb0_q),
    .link_error_i    (err0_q),
    .holdoff_ticks_i (holdoff_q),
    .publish_period_i(period_q),
    .max_step_i      (max_step_q),
    .pub_o           (pub_c),
    .pos_x_o         (px_c),
    .pos_y_o         (py_c),
    .org_lvl_o       (org_c),
    .zoom_o          (zn_c)
  );

  // Carry the tick outcome alongside the view arithmetic
  always_ff @(posedge clk_i) begin
    if (step) begin
      pub1_q <= pub_c;
      px1_q  <= px_c;
      py1_q  <= py_c;
      org1_q <= org_c;
      zn1_q  <= zn_c;
    end
    if (ld.ld2) begin
      pub2_q <= pub1_q;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      org2_q <= org1_q;
      zn2_q  <= zn1_q;
    end
    if (ld.ld3) begin
      pub3_q <= pub2_q;
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      org3_q <= org2_q;
      zn3_q  <= zn2_q;
    end
  end

  mczt_point #(
    .ZOOM_LEVELS(ZOOM_LEVELS),
    .SCREEN     (SCREEN_W),
    .SPAN       (mczt_pkg::SPAN_X)
  ) u_point_x (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .pos_i    (px1_q),
    .s2_org_i (org2_q),
    .s2_zoom_i(zn2_q),
    .s3_pub_i (pub3_q),
    .s3_org_i (org3_q),
    .s3_zoom_i(zn3_q),
    .base_i   (org_x_q),
    .view_o   (view_x)
  );

  mczt_point #(
    .ZOOM_LEVELS(ZOOM_LEVELS),
    .SCREEN     (SCREEN_H),
    .SPAN       (mczt_pkg::SPAN_Y)
  ) u_point_y (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .pos_i    (py1_q),
    .s2_org_i (org2_q),
    .s2_zoom_i(zn2_q),
    .s3_pub_i (pub3_q),
    .s3_org_i (org3_q),
    .s3_zoom_i(zn3_q),
    .base_i   (org_y_q),
    .view_o   (view_y)
  );

  // Result register: zero every field on a quiet tick, and the cursor on a published level change
  assign recentre3 = (zn3_q != org3_q);

  always_ff @(posedge clk_i) begin
    if (ld.ld4) begin
      pub_out_q  <= pub3_q;
      cx_out_q   <= (pub3_q && !recentre3) ? 10'(px3_q) : 10'd0;
      cy_out_q   <= (pub3_q && !recentre3) ? 9'(py3_q) : 9'd0;
      zoom_out_q <= pub3_q ? 4'(zn3_q) : 4'd0;
      vx_out_q   <= pub3_q ? view_x : 32'd0;
      vy_out_q   <= pub3_q ? view_y : 32'd0;
    end
  end

  assign out_valid_o  = out_v_q;
  assign publish_o    = pub_out_q;
  assign cursor_x_o   = cx_out_q;
  assign cursor_y_o   = cy_out_q;
  assign zoom_level_o = zoom_out_q;
  assign view_x_o     = vx_out_q;
  assign view_y_o     = vy_out_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for mouse_cursor_zoom_tracker_core: predicts every tick
// result and checks each output beat. Depends on mczt_pkg and the core RTL only.
module testbench;
  import mczt_pkg::*;

  localparam int unsigned LATENCY     = 4;
  localparam int unsigned SQUEEZE_AT  = 600;
  localparam int unsigned SQUEEZE_LEN = 300;

  typedef struct packed {
    logic       req;
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    logic       err;
  } tick_t;

  typedef struct packed {
    logic        publish;
    logic [9:0]  cx;
    logic [8:0]  cy;
    logic [3:0]  zoom;
    logic [31:0] vx;
    logic [31:0] vy;
  } view_t;

  // Clock, reset and block ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                req_type_i = 1'b0;
  logic [7:0]          header_byte_i = '0;
  logic [7:0]          x_byte_i = '0;
  logic [7:0]          y_byte_i = '0;
  logic                link_error_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                publish_o;
  logic [9:0]          cursor_x_o;
  logic [8:0]          cursor_y_o;
  logic [3:0]          zoom_level_o;
  logic signed [31:0]  view_x_o;
  logic signed [31:0]  view_y_o;

  // Ticks waiting to be driven and the views they are due to produce
  tick_t pending_ticks[$];
  view_t views_due[$];
  int unsigned mismatches = 0;

  // Shadow copy of the registers
  logic [9:0]  cfg_holdoff = HOLDOFF_RST;
  logic [9:0]  cfg_period = PERIOD_RST;
  logic [6:0]  cfg_max_step = MAX_STEP_RST;
  logic [31:0] cfg_origin_x = ORIGIN_X_RST;
  logic [31:0] cfg_origin_y = ORIGIN_Y_RST;

  // Shadow copy of the tracker state
  int          cur_x = POS_RESET;
  int          cur_y = POS_RESET;
  logic [3:0]  zoom_cur = '0;
  logic [3:0]  zoom_shown = '0;
  logic [10:0] hold_cnt = '0;
  logic [9:0]  tick_cnt = '0;
  logic        left_prev = 1'b0;
  logic        right_prev = 1'b0;
  logic [31:0] stack_vx [ZOOM_LEVELS_DEF];
  logic [31:0] stack_vy [ZOOM_LEVELS_DEF];
  bit [ZOOM_LEVELS_DEF-1:0] origin_known = '0;

  // Direction of the cursor drift in the random ticks
  int drift_x = 1;
  int drift_y = -1;

  mouse_cursor_zoom_tracker_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .header_byte_i(header_byte_i),
    .x_byte_i     (x_byte_i),
    .y_byte_i     (y_byte_i),
    .link_error_i (link_error_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .publish_o    (publish_o),
    .cursor_x_o   (cursor_x_o),
    .cursor_y_o   (cursor_y_o),
    .zoom_level_o (zoom_level_o),
    .view_x_o     (view_x_o),
    .view_y_o     (view_y_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  // Nine-bit packet motion divided by eight, truncated toward zero
  function automatic int tick_delta(input logic sgn, input logic [7:0] b);
    int d;
    d = sgn ? int'(b) - 256 : int'(b);
    return d / 8;
  endfunction

  // Saturate near the cap, otherwise count up
  function automatic logic [10:0] next_hold(input logic [10:0] h);
    return (h > 11'(HOLD_CAP)) ? 11'(HOLD_CAP) : h + 11'd1;
  endfunction

  function automatic bit can_move(input int pos, input int d, input int lim);
    int m;
    m = (d < 0) ? -d : d;
    return (m < int'(cfg_max_step)) && (pos + d >= 0) && (pos + d < lim);
  endfunction

  function automatic logic [31:0] view_origin(input bit on_y, input logic [3:0] lvl);
    if (lvl == 0) return on_y ? cfg_origin_y : cfg_origin_x;
    return on_y ? stack_vy[lvl] : stack_vx[lvl];
  endfunction

  // View edge under the cursor: origin plus scaled position, clipped at the top
  function automatic logic [31:0] view_edge(input logic [31:0] origin, input int pos,
                                            input int unsigned span,
                                            input int unsigned screen,
                                            input logic [3:0] lvl);
    longint unsigned off;
    longint sum;
    off = (64'(pos) * 64'(span)) / (64'(screen) << lvl);
    sum = longint'($signed(origin)) + longint'(off);
    if (sum > 64'sd2147483647) return 32'h7FFF_FFFF;
    return sum[31:0];
  endfunction

  // Motion and zoom decision of one tick, against the current state
  function automatic void packet_effect(input tick_t t, input logic [10:0] hold_in,
                                        output int dx, output int dy,
                                        output logic [3:0] z, output logic [10:0] h);
    logic still;
    dx = 0;
    dy = 0;
    z = zoom_cur;
    h = hold_in;
    if (t.req && !t.err) begin
      dx = tick_delta(t.hdr[4], t.xb);
      dy = -tick_delta(t.hdr[5], t.yb);
      still = (dx == 0) && (dy == 0);
      if (still && z < ZOOM_LEVELS_DEF - 1 && left_prev != t.hdr[0] && h >= cfg_holdoff) begin
        z = z + 4'd1;
        h = '0;
      end
      if (still && z != 0 && right_prev != t.hdr[1] && h >= cfg_holdoff) begin
        z = z - 4'd1;
        h = '0;
      end
    end
  endfunction

  // Advance the shadow state by one tick and give the view it publishes
  task automatic advance_tick(input tick_t t, output view_t r);
    int dx, dy;
    logic [3:0] z, o;
    logic [10:0] h;
    logic [31:0] px, py;
    packet_effect(t, next_hold(hold_cnt), dx, dy, z, h);
    if (t.req && !t.err) begin
      if (can_move(cur_x, dx, int'(SCREEN_W_DEF))) cur_x = cur_x + dx;
      if (can_move(cur_y, dy, int'(SCREEN_H_DEF))) cur_y = cur_y + dy;
      left_prev = t.hdr[0];
      right_prev = t.hdr[1];
    end
    zoom_cur = z;
    hold_cnt = h;
    r = '0;
    if (tick_cnt >= cfg_period) begin
      o = zoom_shown;
      px = view_edge(view_origin(1'b0, o), cur_x, SPAN_X, SCREEN_W_DEF, o);
      py = view_edge(view_origin(1'b1, o), cur_y, SPAN_Y, SCREEN_H_DEF, o);
      // zoom-in: the new level starts at the cursor
      if (zoom_cur > o) begin
        stack_vx[zoom_cur] = px;
        stack_vy[zoom_cur] = py;
        origin_known[zoom_cur] = 1'b1;
      end
      if (zoom_cur != o) begin
        cur_x = 0;
        cur_y = 0;
      end
      r.publish = 1'b1;
      r.cx = 10'(cur_x);
      r.cy = 9'(cur_y);
      r.zoom = zoom_cur;
      r.vx = view_origin(1'b0, zoom_cur);
      r.vy = view_origin(1'b1, zoom_cur);
      zoom_shown = zoom_cur;
      tick_cnt = '0;
    end
    tick_cnt = tick_cnt + 10'd1;
  endtask

  task automatic queue_tick(input tick_t t);
    int dx, dy;
    logic [3:0] z;
    logic [10:0] h;
    view_t r;
    packet_effect(t, next_hold(hold_cnt), dx, dy, z, h);
    // drop the packet rather than zoom out onto a level with no stored origin
    if (z < zoom_shown && z != 0 && !origin_known[z]) t.req = 1'b0;
    advance_tick(t, r);
    pending_ticks.push_back(t);
    views_due.push_back(r);
  endtask

  // ------------------------------------------------------------------ stimulus

  function automatic logic [8:0] enc9(input int d);
    return 9'(d);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int unsigned mode;
    logic [8:0] ex, ey;
    t.req = 1'b1;
    t.err = 1'b0;
    t.hdr = 8'($urandom);
    mode = $urandom_range(0, 99);
    if (mode < 50) begin
      // no motion after scaling: button changes may zoom
      ex = enc9(int'($urandom_range(0, 14)) - 7);
      ey = enc9(int'($urandom_range(0, 14)) - 7);
    end else if (mode < 72) begin
      // steady drift towards an edge
      ex = enc9(drift_x * int'($urandom_range(64, 159)));
      ey = enc9(drift_y * int'($urandom_range(64, 159)));
    end else begin
      ex = 9'($urandom);
      ey = 9'($urandom);
      if (mode >= 84 && mode < 92) t.req = 1'b0;
      if (mode >= 92) t.err = 1'b1;
    end
    t.hdr[4] = ex[8];
    t.xb = ex[7:0];
    t.hdr[5] = ey[8];
    t.yb = ey[7:0];
    return t;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HOLDOFF:  cfg_holdoff = v[9:0];
      REG_PERIOD:   cfg_period = v[9:0];
      REG_MAX_STEP: cfg_max_step = v[6:0];
      REG_ORIGIN_X: cfg_origin_x = v;
      REG_ORIGIN_Y: cfg_origin_y = v;
      default: ;
    endcase
  endtask

  task automatic settle_views();
    while (views_due.size() != 0) @(posedge clk_i);
  endtask

  // Reprogram once idle, then queue n random ticks
  task automatic run_phase(input logic [9:0] hold, input logic [9:0] period,
                           input logic [6:0] step, input logic [31:0] ox,
                           input logic [31:0] oy, input int n);
    settle_views();
    write_reg(REG_HOLDOFF, 32'(hold));
    write_reg(REG_PERIOD, 32'(period));
    write_reg(REG_MAX_STEP, 32'(step));
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) drift_x = -drift_x;
      if ($urandom_range(0, 29) == 0) drift_y = -drift_y;
      queue_tick(rand_tick());
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // settings out of reset
    for (int i = 0; i < 40; i++) queue_tick(rand_tick());

    run_phase(10'd0, 10'd4, 7'd64, 32'hC000_0000, 32'h1000_0000, 0);
    // plain tick with every payload bit set
    queue_tick({1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0});
    // link error drops a packet that would zoom
    queue_tick({1'b1, 8'h01, 8'h00, 8'h00, 1'b1});
    // largest positive X, then largest negative X and Y
    queue_tick({1'b1, 8'h00, 8'hFF, 8'h00, 1'b0});
    queue_tick({1'b1, 8'h30, 8'h00, 8'h00, 1'b0});
    // deltas of -1 scale to zero: left press zooms in
    queue_tick({1'b1, 8'h31, 8'hFF, 8'hFF, 1'b0});
    queue_tick({1'b1, 8'h01, 8'h07, 8'h07, 1'b0});
    // right press zooms out
    queue_tick({1'b1, 8'h03, 8'h00, 8'h00, 1'b0});
    // both released together: zoom in and out in one tick
    queue_tick({1'b1, 8'h00, 8'h00, 8'h00, 1'b0});
    // several zoom-ins between two publishes
    queue_tick({1'b1, 8'h01, 8'h00, 8'h00, 1'b0});
    queue_tick({1'b1, 8'h00, 8'h00, 8'h00, 1'b0});
    queue_tick({1'b1, 8'h01, 8'h00, 8'h00, 1'b0});
    repeat (4) queue_tick({1'b0, 8'h00, 8'h00, 8'h00, 1'b0});
    // step of eight moves by one; unused header bits set
    queue_tick({1'b1, 8'hCC, 8'h08, 8'hF8, 1'b0});
    queue_tick({1'b1, 8'hCC, 8'h10, 8'h80, 1'b0});
    // zoom out step by step
    queue_tick({1'b1, 8'h02, 8'h00, 8'h00, 1'b0});
    queue_tick({1'b1, 8'h00, 8'h00, 8'h00, 1'b0});
    queue_tick({1'b1, 8'h02, 8'h00, 8'h00, 1'b0});
    repeat (5) queue_tick({1'b0, 8'h00, 8'h00, 8'h00, 1'b0});

    run_phase(10'd3, 10'd5, 7'd20, 32'hE000_0000, 32'hF000_0000, 100);
    run_phase(10'd0, 10'd0, 7'd64, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 100);
    run_phase(10'd1, 10'd1, 7'd0, 32'h8000_0000, 32'h8000_0000, 80);
    run_phase(10'd1023, 10'd1023, 7'd127, 32'($urandom), 32'($urandom), 60);
    run_phase(10'd10, 10'd2, 7'd1, 32'($urandom), 32'($urandom), 80);
    run_phase(10'd0, 10'd7, 7'd32, 32'($urandom), 32'($urandom), 100);
    // long stretch: the hold-off saturates and zooms only on alternate ticks
    run_phase(10'd1001, 10'd37, 7'd40, 32'hE000_0000, 32'hF000_0000, 930);

    settle_views();
    repeat (LATENCY * 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ------------------------------------------------------------------- driver

  int unsigned gap_left = 0;
  logic        quiet_in = 1'b0;

  // Offer the next tick once the slot is free and the drawn gap has passed
  always @(posedge clk_i) begin : drive_ticks
    tick_t t;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        t = pending_ticks.pop_front();
        req_type_i <= t.req;
        header_byte_i <= t.hdr;
        x_byte_i <= t.xb;
        y_byte_i <= t.yb;
        link_error_i <= t.err;
        in_valid_i <= 1'b1;
        gap_left <= quiet_in ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 63) == 0) quiet_in <= !quiet_in;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  int unsigned stall_left = 0;
  int unsigned views_seen = 0;
  logic        quiet_out = 1'b0;

  task automatic check_field(input string what, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Check each view beat, then draw the stall before the next one
  always @(posedge clk_i) begin : watch_views
    view_t got, want;
    int unsigned stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      got = {publish_o, cursor_x_o, cursor_y_o, zoom_level_o, view_x_o, view_y_o};
      if (views_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %0h", $time, got);
        mismatches++;
      end else begin
        want = views_due.pop_front();
        check_field("publish", want.publish, got.publish);
        check_field("cursor_x", want.cx, got.cx);
        check_field("cursor_y", want.cy, got.cy);
        check_field("zoom_level", want.zoom, got.zoom);
        check_field("view_x", want.vx, got.vx);
        check_field("view_y", want.vy, got.vy);
      end
      views_seen <= views_seen + 1;
      // hold off once for long enough to back up the input
      if (views_seen == SQUEEZE_AT) stall = SQUEEZE_LEN;
      else stall = quiet_out ? 0 : $urandom_range(0, 13);
      stall_left <= stall;
      out_ready_i <= (stall == 0);
      if ($urandom_range(0, 63) == 0) quiet_out <= !quiet_out;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

endmodule
